[design/csd_pkg.sv]
// Shared types, constants and the LED wiring decode for the charlieplex display scanner.
// No dependencies; every other file of the block imports this package.
package csd_pkg;

    localparam int ROWS = 5;
    localparam int COLUMNS = 18;
    localparam int ROW_W = 3;
    localparam int COL_W = 5;
    localparam int ADDR_W = 4;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    // Port D pattern shown while the scanned pixel is dark: only pin D1 driven high.
    localparam logic [6:0] DARK_PORTD = 7'h02;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SWAP  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [2:0] ddrb;
        logic [2:0] portb;
        logic [6:0] ddrd;
        logic [6:0] portd;
        logic       lit;
    } result_t;

    function automatic logic [7:0] bit_of(input logic [4:0] n);
        logic [7:0] one;
        one = 8'd1;
        return (n < 5'd8) ? (one << n[2:0]) : 8'd0;
    endfunction

    // Port patterns that light the LED at row r and wired column c.
    function automatic result_t led_wiring(input logic [2:0] r, input logic [4:0] c);
        logic [4:0] rr;
        logic [4:0] cc;
        logic [7:0] db;
        logic [7:0] pb;
        logic [7:0] dd;
        logic [7:0] pd;
        result_t    w;
        rr = {2'b00, r};
        cc = c;
        db = 8'd0;
        pb = 8'd0;
        dd = 8'd0;
        pd = 8'd0;
        case (c) inside
            [5'd6:5'd8]:
            begin
                dd = bit_of(rr);
                db = bit_of(c - 5'd6);
                pb = db;
            end
            [5'd9:5'd14]:
            begin
                if (c == 5'd14 && r == 3'd0)
                begin
                    cc = 5'd15;
                end
                dd = bit_of(cc - 5'd9);
                pd = dd;
                if (r <= 3'd1)
                begin
                    dd = dd | bit_of(rr + 5'd5);
                end
                else
                begin
                    db = bit_of(rr - 5'd2);
                end
            end
            5'd15:
            begin
                if (r <= 3'd1)
                begin
                    dd = bit_of(rr + 5'd5);
                    db = 8'd1;
                    pb = 8'd1;
                end
                else
                begin
                    dd = bit_of(5'd6);
                    pd = dd;
                    db = bit_of(rr - 5'd2);
                end
            end
            5'd16:
            begin
                if (r <= 3'd1)
                begin
                    dd = bit_of(rr + 5'd5);
                    db = 8'd2;
                    pb = 8'd2;
                end
                else if (r == 3'd2)
                begin
                    db = 8'd3;
                    pb = 8'd2;
                end
                else if (r == 3'd3)
                begin
                    db = 8'd3;
                    pb = 8'd1;
                end
                else
                begin
                    db = 8'd5;
                    pb = 8'd1;
                end
            end
            5'd17:
            begin
                if (r <= 3'd1)
                begin
                    dd = bit_of(rr + 5'd5);
                    db = 8'd4;
                    pb = 8'd4;
                end
                else if (r == 3'd2)
                begin
                    db = 8'd5;
                    pb = 8'd4;
                end
                else if (r == 3'd3)
                begin
                    db = 8'd6;
                    pb = 8'd4;
                end
                else
                begin
                    db = 8'd6;
                    pb = 8'd2;
                end
            end
            default:
            begin
                // Columns 0 to 5 skip the pin that the row itself drives.
                if (c >= rr)
                begin
                    cc = c + 5'd1;
                end
                dd = bit_of(cc) | bit_of(rr);
                pd = bit_of(cc);
            end
        endcase
        w.ddrb  = db[2:0];
        w.portb = pb[2:0];
        w.ddrd  = dd[6:0];
        w.portd = pd[6:0];
        w.lit   = 1'b1;
        return w;
    endfunction

endpackage

[design/csd_frame_store.sv]
// Double-buffered frame store: two banks of five 18-bit rows, cleared at reset.
// Depends on csd_pkg for the row and address widths.
module csd_frame_store
    import csd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [COLUMNS-1:0]   wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [COLUMNS-1:0]   rd_data
);

    logic [COLUMNS-1:0] rows_reg [2*ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2*ROWS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            rows_reg[wr_addr] <= wr_data;
        end
    end

    // Each read address is always below ten; the decode keeps it in range.
    assign rd_data = rows_reg[rd_addr];

endmodule

[design/csd_out_stage.sv]
// Output register with a one-word skid stage so the input side keeps moving
// while a result waits. Depends on csd_pkg for the result word type.
module csd_out_stage
    import csd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // No push can arrive while the skid word is held.
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push && out_valid_reg && !pop)
        begin
            skid_data_reg <= push_data;
        end
        else if (push)
        begin
            out_data_reg <= push_data;
        end
    end

endmodule

[design/charlieplex_display_scanner_core.sv]
// Top level of the charlieplex display scanner: command decode, scan position,
// pixel lookup and port pattern decode. Depends on csd_pkg, csd_frame_store, csd_out_stage.
//
// The block drives a charlieplexed 5 by 18 LED matrix from a double-buffered frame.
// Each input word carries a command. A write command stores row_bits into row
// row_index of the back buffer (row indexes of 5 or more are ignored); a swap command
// exchanges the front and back buffers; neither produces an output word. A scan tick
// looks up the front-buffer pixel at the current row and column and produces exactly
// one output word: the port B and port D direction and level bits that light that LED
// through the fixed wiring (the column is mirrored, so frame column y lights wired
// column 17 - y), or the dark pattern (only pin D1 driven high) when the pixel is clear.
// Row and column then step together, wrapping at 5 and 18. Command code 3 is ignored.
// The lookup and wiring decode sit combinationally between the state and frame registers
// and the output register, so one word is accepted on every clock while in_ready is high.
// A one-word skid stage behind the output register lets the block take one more word
// while a result waits; in_ready drops only when both output slots are full. The frame
// store is cleared by reset itself, so the block is ready right after reset.
module charlieplex_display_scanner_core
    import csd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   cmd,
    input  logic [2:0]   row_index,
    input  logic [17:0]  row_bits,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   ddrb_bits,
    output logic [2:0]   portb_bits,
    output logic [6:0]   ddrd_bits,
    output logic [6:0]   portd_bits,
    output logic         led_lit
);

    logic [ROW_W-1:0]   scan_row_reg;
    logic [ROW_W-1:0]   scan_row_next;
    logic [COL_W-1:0]   scan_col_reg;
    logic [COL_W-1:0]   scan_col_next;
    logic               front_sel_reg;
    logic               front_sel_next;

    logic               accept;
    logic               is_tick;
    logic               is_write;
    logic               is_swap;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COLUMNS-1:0] front_row;
    logic               pixel;
    logic [COL_W-1:0]   wired_col;
    result_t            result;
    result_t            out_word;
    logic               push_ready;

    assign accept   = in_valid && in_ready;
    assign is_tick  = (cmd == CMD_TICK);
    assign is_write = (cmd == CMD_WRITE);
    assign is_swap  = (cmd == CMD_SWAP);

    // Bank 0 holds rows 0 to 4 and bank 1 rows 5 to 9; writes go to the bank not shown.
    assign wr_en   = accept && is_write && (row_index <= LAST_ROW);
    assign wr_addr = front_sel_reg ? {1'b0, row_index} : ({1'b0, row_index} + ADDR_W'(ROWS));
    assign rd_addr = front_sel_reg ? ({1'b0, scan_row_reg} + ADDR_W'(ROWS)) : {1'b0, scan_row_reg};

    csd_frame_store u_frame_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (row_bits),
        .rd_addr (rd_addr),
        .rd_data (front_row)
    );

    // Pixel test and wiring decode for the LED under the scan position.
    assign pixel     = front_row[scan_col_reg];
    assign wired_col = LAST_COL - scan_col_reg;

    always_comb
    begin
        if (pixel)
        begin
            result = led_wiring(scan_row_reg, wired_col);
        end
        else
        begin
            result.ddrb  = 3'd0;
            result.portb = 3'd0;
            result.ddrd  = DARK_PORTD;
            result.portd = DARK_PORTD;
            result.lit   = 1'b0;
        end
    end

    // Scan position and buffer select advance only on accepted words.
    always_comb
    begin
        scan_row_next  = scan_row_reg;
        scan_col_next  = scan_col_reg;
        front_sel_next = front_sel_reg;
        if (accept && is_tick)
        begin
            scan_row_next = (scan_row_reg == LAST_ROW) ? '0 : scan_row_reg + ROW_W'(1);
            scan_col_next = (scan_col_reg == LAST_COL) ? '0 : scan_col_reg + COL_W'(1);
        end
        if (accept && is_swap)
        begin
            front_sel_next = !front_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
            front_sel_reg <= 1'b0;
        end
        else
        begin
            scan_row_reg  <= scan_row_next;
            scan_col_reg  <= scan_col_next;
            front_sel_reg <= front_sel_next;
        end
    end

    assign in_ready = push_ready;

    csd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && is_tick),
        .push_data  (result),
        .push_ready (push_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_word)
    );

    assign ddrb_bits  = out_word.ddrb;
    assign portb_bits = out_word.portb;
    assign ddrd_bits  = out_word.ddrd;
    assign portd_bits = out_word.portd;
    assign led_lit    = out_word.lit;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for charlieplex_display_scanner_core.
// Depends on csd_pkg and the scanner RTL; it carries its own scan predictor and wiring decode.
module tb_top
    import csd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Command code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [17:0] ALL_COLUMNS = 18'h3FFFF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_TICK;
    logic [2:0]  row_index = '0;
    logic [17:0] row_bits = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  ddrb_bits;
    logic [2:0]  portb_bits;
    logic [6:0]  ddrd_bits;
    logic [6:0]  portd_bits;
    logic        led_lit;

    // Predictor state: scan position, both frame buffers and the front select bit.
    logic [2:0]  scan_row_q;
    logic [4:0]  scan_col_q;
    logic [17:0] shadow_frame [0:2*ROWS-1];
    logic        shadow_front;

    // Port patterns still owed by the block, oldest first.
    result_t     patterns_due [$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  words_sent = 0;
    int  ticks_sent = 0;
    int  patterns_checked = 0;
    int  lit_checked = 0;
    int  quiet_words = 0;
    bit  calm_phase = 1'b0;

    charlieplex_display_scanner_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .row_index  (row_index),
        .row_bits   (row_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ddrb_bits  (ddrb_bits),
        .portb_bits (portb_bits),
        .ddrd_bits  (ddrd_bits),
        .portd_bits (portd_bits),
        .led_lit    (led_lit)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block stalls forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d patterns outstanding",
                     $realtime, cycle_count, patterns_due.size());
            $display("FAIL charlieplex_display_scanner_core");
            $finish;
        end
    end

    // One-hot pin mask; pins past bit 7 do not exist on the port.
    function automatic logic [7:0] pin(input int n);
        return (n >= 0 && n < 8) ? (8'd1 << n) : 8'd0;
    endfunction

    // Port pattern that lights LED (r, wired column c) through the fixed charlieplex wiring.
    function automatic result_t lit_pattern(input int r, input int c);
        logic [7:0] db;
        logic [7:0] pb;
        logic [7:0] dd;
        logic [7:0] pd;
        int         k;
        result_t    pat;
        db = '0;
        pb = '0;
        dd = '0;
        pd = '0;
        if (c >= 6 && c <= 8)
        begin
            // Port B pins 0 to 2 are the high side, the row pin on port D the low side.
            dd = pin(r);
            db = pin(c - 6);
            pb = db;
        end
        else if (c >= 9 && c <= 14)
        begin
            // Row 0 of wired column 14 is routed like column 15.
            k = (c == 14 && r == 0) ? 15 : c;
            dd = pin(k - 9);
            pd = dd;
            if (r <= 1)
                dd = dd | pin(r + 5);
            else
                db = pin(r - 2);
        end
        else if (c == 15)
        begin
            if (r <= 1)
            begin
                dd = pin(r + 5);
                db = 8'd1;
                pb = 8'd1;
            end
            else
            begin
                dd = pin(6);
                pd = dd;
                db = pin(r - 2);
            end
        end
        else if (c == 16 || c == 17)
        begin
            // These two columns only use port B for rows 2 to 4.
            if (r <= 1)
            begin
                dd = pin(r + 5);
                db = (c == 16) ? 8'd2 : 8'd4;
                pb = db;
            end
            else if (c == 16)
            begin
                db = (r == 4) ? 8'd5 : 8'd3;
                pb = (r == 2) ? 8'd2 : 8'd1;
            end
            else
            begin
                db = (r == 2) ? 8'd5 : 8'd6;
                pb = (r == 4) ? 8'd2 : 8'd4;
            end
        end
        else
        begin
            // The low columns step over the pin that the row drives.
            k = (c >= r) ? c + 1 : c;
            dd = pin(k) | pin(r);
            pd = pin(k);
        end
        pat.ddrb  = db[2:0];
        pat.portb = pb[2:0];
        pat.ddrd  = dd[6:0];
        pat.portd = pd[6:0];
        pat.lit   = 1'b1;
        return pat;
    endfunction

    // Applies one accepted word to the predictor and queues the pattern a tick owes.
    task automatic advance_scanner(input logic [1:0] code, input logic [2:0] ri,
                                   input logic [17:0] bits);
        logic [17:0] front_row;
        result_t     pat;
        case (code)
            CMD_WRITE:
            begin
                // Rows past the last one are dropped.
                if (ri < ROWS)
                    shadow_frame[(shadow_front ? 0 : ROWS) + int'(ri)] = bits;
            end
            CMD_SWAP:
            begin
                shadow_front = ~shadow_front;
            end
            CMD_TICK:
            begin
                front_row = shadow_frame[(shadow_front ? ROWS : 0) + int'(scan_row_q)];
                if (front_row[scan_col_q])
                begin
                    // The frame column is mirrored onto the wiring.
                    pat = lit_pattern(int'(scan_row_q), COLUMNS - 1 - int'(scan_col_q));
                end
                else
                begin
                    pat.ddrb  = '0;
                    pat.portb = '0;
                    pat.ddrd  = DARK_PORTD;
                    pat.portd = DARK_PORTD;
                    pat.lit   = 1'b0;
                end
                patterns_due.push_back(pat);
                scan_row_q = (scan_row_q == LAST_ROW) ? '0 : scan_row_q + 3'd1;
                scan_col_q = (scan_col_q == LAST_COL) ? '0 : scan_col_q + 5'd1;
                ticks_sent++;
            end
            default:
            begin
                // Unused code: nothing changes.
            end
        endcase
    endtask

    // Sends one word, with an optional idle burst in front, and waits for it to be taken.
    // It returns right after the accepting edge, so the next call may keep valid high.
    task automatic send_word(input logic [1:0] code, input logic [2:0] ri,
                             input logic [17:0] bits);
        int gap;
        gap = 0;
        if (!calm_phase)
        begin
            if (quiet_words > 0)
                quiet_words--;
            else if ($urandom_range(0, 9) == 0)
                quiet_words = $urandom_range(20, 60);
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 14);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= code;
        row_index <= ri;
        row_bits  <= bits;
        // Inputs settle after this edge; the sampled ready of later edges decides acceptance.
        do
            @(posedge clk);
        while (!in_ready);
        advance_scanner(code, ri, bits);
        words_sent++;
    endtask

    // Holds the sender off until every owed pattern has come back.
    task automatic drain_patterns();
        in_valid <= 1'b0;
        while (patterns_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The receiver stalls in bursts, and sits ready for stretches in between.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (calm_phase || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // Compares every accepted output word with the oldest owed pattern.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (patterns_due.size() == 0)
            begin
                $display("%0t: output word with nothing owed: ddrb=%h portb=%h ddrd=%h",
                         $realtime, ddrb_bits, portb_bits, ddrd_bits);
                $display("%0t: portd=%h lit=%b", $realtime, portd_bits, led_lit);
                mismatch_count++;
            end
            else
            begin
                want = patterns_due.pop_front();
                patterns_checked++;
                if (want.lit)
                    lit_checked++;
                if (ddrb_bits !== want.ddrb)
                begin
                    $display("%0t: ddrb_bits expected %h actual %h", $realtime, want.ddrb, ddrb_bits);
                    mismatch_count++;
                end
                if (portb_bits !== want.portb)
                begin
                    $display("%0t: portb_bits expected %h actual %h",
                             $realtime, want.portb, portb_bits);
                    mismatch_count++;
                end
                if (ddrd_bits !== want.ddrd)
                begin
                    $display("%0t: ddrd_bits expected %h actual %h", $realtime, want.ddrd, ddrd_bits);
                    mismatch_count++;
                end
                if (portd_bits !== want.portd)
                begin
                    $display("%0t: portd_bits expected %h actual %h",
                             $realtime, want.portd, portd_bits);
                    mismatch_count++;
                end
                if (led_lit !== want.lit)
                begin
                    $display("%0t: led_lit expected %b actual %b", $realtime, want.lit, led_lit);
                    mismatch_count++;
                end
            end
        end
    end

    // A freshly cleared frame is dark even after the back buffer is written.
    task automatic test_dark_after_reset();
        send_word(CMD_WRITE, 3'd0, ALL_COLUMNS);
        send_word(CMD_TICK, 3'd7, ALL_COLUMNS);
        send_word(CMD_TICK, 3'd0, 18'h00000);
    endtask

    // Fills the back buffer, checks ignored words, then swaps and scans a lit frame.
    task automatic test_full_frame_swap();
        for (int r = 1; r < ROWS; r++)
            send_word(CMD_WRITE, 3'(r), ALL_COLUMNS);
        // An out-of-range row and the unused code must leave the frame alone.
        send_word(CMD_WRITE, 3'd7, 18'h00000);
        send_word(CMD_UNUSED, 3'd5, 18'h00000);
        send_word(CMD_SWAP, 3'd0, 18'h00000);
        repeat (10) send_word(CMD_TICK, 3'd0, 18'h00000);
    endtask

    // Clears one row behind the display and swaps back and forth.
    task automatic test_clear_row_and_swap();
        send_word(CMD_WRITE, 3'd4, 18'h00000);
        send_word(CMD_SWAP, 3'd3, ALL_COLUMNS);
        send_word(CMD_TICK, 3'd0, 18'h00000);
        send_word(CMD_SWAP, 3'd0, 18'h00000);
        send_word(CMD_TICK, 3'd0, 18'h00000);
    endtask

    // Mostly ticks and row writes with random content; some swaps and ignored words.
    task automatic test_random_traffic(input int n_words);
        int          counted;
        int          pick;
        logic [17:0] bits;
        counted = 0;
        while (counted < n_words)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       bits = ALL_COLUMNS;
                1:       bits = 18'h00000;
                2:       bits = 18'd1 << $urandom_range(0, COLUMNS - 1);
                default: bits = 18'($urandom());
            endcase
            if (pick < 55)
            begin
                send_word(CMD_TICK, 3'($urandom()), 18'($urandom()));
                counted++;
            end
            else if (pick < 80)
            begin
                send_word(CMD_WRITE, 3'($urandom_range(0, ROWS - 1)), bits);
                counted++;
            end
            else if (pick < 88)
            begin
                send_word(CMD_SWAP, 3'($urandom()), 18'($urandom()));
                counted++;
            end
            else if (pick < 94)
            begin
                send_word(CMD_WRITE, 3'($urandom_range(ROWS, 7)), bits);
            end
            else
            begin
                send_word(CMD_UNUSED, 3'($urandom()), bits);
            end
        end
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_full_rate(input int n_words);
        calm_phase = 1'b1;
        test_random_traffic(n_words);
    endtask

    initial
    begin
        scan_row_q = '0;
        scan_col_q = '0;
        shadow_front = 1'b0;
        for (int i = 0; i < 2 * ROWS; i++)
            shadow_frame[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_dark_after_reset();
        test_full_frame_swap();
        test_clear_row_and_swap();
        test_random_traffic(600);
        drain_patterns();
        test_random_traffic(420);
        test_full_rate(120);

        in_valid <= 1'b0;
        while (patterns_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words, %0d of them scan ticks, with random idling on both sides.",
                 words_sent, ticks_sent);
        $display("Checked %0d port patterns, %0d lit; %0d field mismatches.",
                 patterns_checked, lit_checked, mismatch_count);
        if (mismatch_count == 0 && patterns_due.size() == 0)
            $display("PASS charlieplex_display_scanner_core");
        else
            $display("FAIL charlieplex_display_scanner_core");
        $finish;
    end

endmodule
